// ===== sv/admm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// admm_pkg
// shared register indexes and reset values for the rho predictor
// ----------------------------------------------------------------------------
package admm_pkg;

  localparam int CfgBits = 32;
  localparam int IdxBits = 2;

  typedef enum logic [IdxBits-1:0] {
    REG_CLIP_ENABLE = 2'd0,
    REG_RHO_MINIMUM = 2'd1,
    REG_RHO_MAXIMUM = 2'd2
  } reg_index_t;

  localparam logic [CfgBits-1:0] RhoMinReset = 32'd6554;
  localparam logic [CfgBits-1:0] RhoMaxReset = 32'd6553600;

endpackage

// ===== sv/admm_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// admm_div_cell
// one restoring divide step: shifts in one dividend bit, produces one
// quotient bit, with a sticky flag once the quotient exceeds the word
// ----------------------------------------------------------------------------
module admm_div_cell #(
  parameter int W  = 32,
  parameter int NB = 48,
  parameter int K  = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_vld,
  input  logic [NB-1:0] in_num,
  input  logic [W:0]    in_den,
  input  logic [W:0]    in_rem,
  input  logic [W:0]    in_quo,
  input  logic          in_ovf,
  output logic          out_vld,
  output logic [NB-1:0] out_num,
  output logic [W:0]    out_den,
  output logic [W:0]    out_rem,
  output logic [W:0]    out_quo,
  output logic          out_ovf
);

  logic [W+1:0] rem_sh;
  logic [W+1:0] rem_sub;
  logic         take;
  logic [W:0]   quo_nx;

  // trial subtract
  always_comb begin
    rem_sh  = {in_rem, in_num[K]};
    take    = rem_sh >= {1'b0, in_den};
    rem_sub = take ? (rem_sh - {1'b0, in_den}) : rem_sh;
    quo_nx  = {in_quo[W-1:0], take};
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else     out_vld <= in_vld;
    out_num <= in_num;
    out_den <= in_den;
    out_rem <= rem_sub[W:0];
    out_quo <= quo_nx;
    out_ovf <= in_ovf | quo_nx[W] | in_quo[W];
  end

endmodule

// ===== sv/admm_div_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// admm_div_chain
// row of divide cells computing floor((a << F) / d) saturated to the word
// ----------------------------------------------------------------------------
module admm_div_chain #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_vld,
  input  logic [W-1:0] num,
  input  logic [W:0]   den,
  output logic         out_vld,
  output logic [W-1:0] quo
);

  localparam int NB = W + F;

  logic          v [NB+1];
  logic [NB-1:0] n [NB+1];
  logic [W:0]    d [NB+1];
  logic [W:0]    r [NB+1];
  logic [W:0]    q [NB+1];
  logic          o [NB+1];

  assign v[0] = in_vld;
  assign n[0] = {num, {F{1'b0}}};
  assign d[0] = den;
  assign r[0] = '0;
  assign q[0] = '0;
  assign o[0] = 1'b0;

  // one cell per quotient bit, msb first
  for (genvar i = 0; i < NB; i++) begin : g_cell
    admm_div_cell #(.W(W), .NB(NB), .K(NB-1-i)) u_cell (
      .clk(clk), .rst(rst), .in_vld(v[i]), .in_num(n[i]), .in_den(d[i]),
      .in_rem(r[i]), .in_quo(q[i]), .in_ovf(o[i]),
      .out_vld(v[i+1]), .out_num(n[i+1]), .out_den(d[i+1]),
      .out_rem(r[i+1]), .out_quo(q[i+1]), .out_ovf(o[i+1])
    );
  end

  assign out_vld = v[NB];
  assign quo     = (o[NB] | q[NB][W]) ? {W{1'b1}} : q[NB][W-1:0];

endmodule

// ===== sv/admm_sqrt_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// admm_sqrt_chain
// row of digit-by-digit square root cells: floor(sqrt(x << F))
// ----------------------------------------------------------------------------
module admm_sqrt_chain #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_vld,
  input  logic [W-1:0] x,
  output logic         out_vld,
  output logic [W-1:0] root
);

  localparam int P  = (W + F + 1) / 2;
  localparam int RB = P + 2;

  logic [2*P-1:0] s [P+1];
  logic [RB-1:0]  r [P+1];
  logic [P-1:0]   q [P+1];
  logic           v [P+1];

  logic [2*P-1:0] x_ext;
  assign x_ext = (2*P)'({x, {F{1'b0}}});

  assign s[0] = x_ext;
  assign r[0] = '0;
  assign q[0] = '0;
  assign v[0] = in_vld;

  // each cell resolves one root bit
  for (genvar i = 0; i < P; i++) begin : g_cell
    logic [RB-1:0] rs;
    logic [RB-1:0] tr;
    logic          take;
    always_comb begin
      rs   = {r[i][RB-3:0], s[i][2*(P-1-i)+1], s[i][2*(P-1-i)]};
      tr   = {q[i], 2'b01};
      take = rs >= tr;
    end
    always_ff @(posedge clk) begin
      if (rst) v[i+1] <= 1'b0;
      else     v[i+1] <= v[i];
      s[i+1] <= s[i];
      r[i+1] <= take ? (rs - tr) : rs;
      q[i+1] <= {q[i][P-2:0], take};
    end
  end

  assign out_vld = v[P];
  assign root    = W'(q[P]);

endmodule

// ===== sv/admm_rho_predictor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// admm_rho_predictor
// residual-balancing penalty update: rho * sqrt((p/ps) / (d/ds))
// ----------------------------------------------------------------------------
// Takes one transaction per cycle when start is high; busy is always low.
// Each result appears on rho_next and saturated with done high for one cycle.
// Each result passes through the chain of one-bit divide cells (two residual
// divides in parallel, then the ratio divide) and the one-bit-per-cell root
// chain, followed by a multiply stage and a clip stage. The receiver cannot
// stall.
// ----------------------------------------------------------------------------
module admm_rho_predictor #(
  parameter int WORD_BITS     = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [WORD_BITS-1:0]           primal_residual,
  input  logic [WORD_BITS-1:0]           dual_residual,
  input  logic [WORD_BITS-1:0]           primal_scale,
  input  logic [WORD_BITS-1:0]           dual_scale,
  input  logic [WORD_BITS-1:0]           rho_now,
  input  logic                           cfg_we,
  input  logic [admm_pkg::IdxBits-1:0]   cfg_index,
  input  logic [admm_pkg::CfgBits-1:0]   cfg_data,
  output logic                           done,
  output logic [WORD_BITS-1:0]           rho_next,
  output logic                           saturated
);
  import admm_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int F  = FRACTION_BITS;
  localparam int DL = W + F;
  localparam int SL = (W + F + 1) / 2;
  localparam int RL = 2 * DL + SL;

  logic         clip_enable;
  logic [W-1:0] rho_minimum;
  logic [W-1:0] rho_maximum;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_enable <= 1'b1;
      rho_minimum <= W'(RhoMinReset);
      rho_maximum <= W'(RhoMaxReset);
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_CLIP_ENABLE: clip_enable <= cfg_data[0];
        REG_RHO_MINIMUM: rho_minimum <= W'(cfg_data);
        REG_RHO_MAXIMUM: rho_maximum <= W'(cfg_data);
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic         vin;
  assign vin = start & ~rst;

  // residual normalization
  logic         pv, dv;
  logic [W-1:0] npri, ndua;
  admm_div_chain #(.W(W), .F(F)) u_pdiv (
    .clk(clk), .rst(rst), .in_vld(vin), .num(primal_residual),
    .den({1'b0, primal_scale} + 1'b1), .out_vld(pv), .quo(npri)
  );
  admm_div_chain #(.W(W), .F(F)) u_ddiv (
    .clk(clk), .rst(rst), .in_vld(vin), .num(dual_residual),
    .den({1'b0, dual_scale} + 1'b1), .out_vld(dv), .quo(ndua)
  );

  // ratio and root
  logic         rv, sv;
  logic [W-1:0] ratio, root;
  admm_div_chain #(.W(W), .F(F)) u_rdiv (
    .clk(clk), .rst(rst), .in_vld(pv), .num(npri),
    .den({1'b0, ndua} + 1'b1), .out_vld(rv), .quo(ratio)
  );
  admm_sqrt_chain #(.W(W), .F(F)) u_sqrt (
    .clk(clk), .rst(rst), .in_vld(rv), .x(ratio), .out_vld(sv), .root(root)
  );

  // rho delay line alongside the arithmetic cells
  logic [W-1:0] rho_dly [RL+1];
  assign rho_dly[0] = rho_now;
  for (genvar i = 0; i < RL; i++) begin : g_rho
    always_ff @(posedge clk) rho_dly[i+1] <= rho_dly[i];
  end

  // multiply stage
  logic [2*W-1:0] prod;
  logic           mv;
  always_ff @(posedge clk) begin
    if (rst) mv <= 1'b0;
    else     mv <= sv;
    prod <= rho_dly[RL] * root;
  end

  logic [2*W-F-1:0] shifted;
  logic             movf;
  logic [W-1:0]     val;
  logic [W-1:0]     clipped;
  logic             sat;
  always_comb begin
    shifted = prod[2*W-1:F];
    movf    = |shifted[2*W-F-1:W];
    val     = movf ? {W{1'b1}} : shifted[W-1:0];
    clipped = val;
    sat     = movf;
    if (clip_enable) begin
      if (clipped < rho_minimum) begin
        clipped = rho_minimum;
        sat     = 1'b1;
      end
      if (clipped > rho_maximum) begin
        clipped = rho_maximum;
        sat     = 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= mv;
    rho_next  <= clipped;
    saturated <= sat;
  end

  // the two residual chains run in lockstep
  assert property (@(posedge clk) disable iff (rst) pv == dv)
    else $error("residual divide chains out of step");

  // a result never exceeds the upper bound while clipping
  assert property (@(posedge clk) disable iff (rst)
    done && $past(clip_enable) && !$past(cfg_we) |-> rho_next <= rho_maximum)
    else $error("clipped rho above maximum");

  // every valid leaving the multiply stage is reported as a done strobe
  assert property (@(posedge clk) disable iff (rst) mv |=> done)
    else $error("result strobe lost");

endmodule

// ===== tb/rho_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rho_checker
// predicts rho_next/saturated for every accepted transaction and compares
// ----------------------------------------------------------------------------
// Watches the command and result channels of the rho predictor and the
// register write port. Register shadows are updated on every write. Each
// accepted transaction produces one expected result, computed bit by bit
// with floor division, floor square root and a saturating multiply, and
// queued in order. Each strobed result is compared against the oldest entry.
// ----------------------------------------------------------------------------
module rho_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [31:0] primal_residual,
  input  logic [31:0] dual_residual,
  input  logic [31:0] primal_scale,
  input  logic [31:0] dual_scale,
  input  logic [31:0] rho_now,
  input  logic        cfg_we,
  input  logic [admm_pkg::IdxBits-1:0] cfg_index,
  input  logic [admm_pkg::CfgBits-1:0] cfg_data,
  input  logic        done,
  input  logic [31:0] rho_next,
  input  logic        saturated,
  output int          pending,
  output int          fail_count
);
  import admm_pkg::*;

  localparam int WB = 32;
  localparam int FB = 16;
  localparam logic [63:0] WORD_MAX = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] rho;
    logic        sat;
  } rho_result_t;

  logic        clip_on;
  logic [31:0] bound_lo;
  logic [31:0] bound_hi;
  rho_result_t expected_rho_q[$];

  assign pending = expected_rho_q.size();

  // floor((a << F) / d) saturated at the word maximum
  function automatic logic [63:0] q_divide(logic [63:0] a, logic [63:0] d);
    logic [63:0] rem;
    logic [63:0] q;
    logic        b;
    rem = 0;
    q = 0;
    for (int k = WB + FB - 1; k >= 0; k--) begin
      b = (k < FB) ? 1'b0 : a[k - FB];
      rem = (rem << 1) | b;
      q = q << 1;
      if (rem >= d) begin
        rem = rem - d;
        q[0] = 1'b1;
      end
      if (q > WORD_MAX) return WORD_MAX;
    end
    return q;
  endfunction

  // floor(sqrt(x << F))
  function automatic logic [63:0] q_root(logic [63:0] x);
    logic [127:0] s;
    logic [63:0]  rem;
    logic [63:0]  root;
    logic [63:0]  trial;
    s = {64'd0, x} << FB;
    rem = 0;
    root = 0;
    for (int i = (WB + FB + 1) / 2 - 1; i >= 0; i--) begin
      rem = (rem << 2) | s[2*i +: 2];
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic rho_result_t compute_expected(logic [31:0] p, logic [31:0] d,
                                                   logic [31:0] ps, logic [31:0] ds,
                                                   logic [31:0] r);
    logic [63:0]  np;
    logic [63:0]  nd;
    logic [63:0]  ratio;
    logic [63:0]  root;
    logic [127:0] prod;
    logic [63:0]  val;
    rho_result_t  res;
    np = q_divide(p, {32'd0, ps} + 1);
    nd = q_divide(d, {32'd0, ds} + 1);
    ratio = q_divide(np, nd + 1);
    root = q_root(ratio);
    prod = ({64'd0, r} * {64'd0, root}) >> FB;
    res.sat = 1'b0;
    if (prod > WORD_MAX) begin
      val = WORD_MAX;
      res.sat = 1'b1;
    end else begin
      val = prod[63:0];
    end
    if (clip_on) begin
      if (val < bound_lo) begin
        val = bound_lo;
        res.sat = 1'b1;
      end
      if (val > bound_hi) begin
        val = bound_hi;
        res.sat = 1'b1;
      end
    end
    res.rho = val[31:0];
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t MISMATCH: %s", $realtime, msg);
    fail_count++;
  endtask

  initial fail_count = 0;

  // register shadow, prediction and comparison
  always @(posedge clk) begin
    rho_result_t got;
    rho_result_t exp_r;
    if (rst) begin
      clip_on <= 1'b1;
      bound_lo <= RhoMinReset;
      bound_hi <= RhoMaxReset;
      expected_rho_q.delete();
    end else begin
      if (done) begin
        got.rho = rho_next;
        got.sat = saturated;
        if (expected_rho_q.size() == 0) begin
          report_mismatch("result transaction with no expectation");
        end else begin
          exp_r = expected_rho_q.pop_front();
          if (got.rho !== exp_r.rho)
            report_mismatch($sformatf("rho_next %h expected %h", got.rho, exp_r.rho));
          if (got.sat !== exp_r.sat)
            report_mismatch($sformatf("saturated %b expected %b", got.sat, exp_r.sat));
        end
      end
      if (start && !busy)
        expected_rho_q.push_back(compute_expected(primal_residual, dual_residual,
                                                  primal_scale, dual_scale, rho_now));
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_CLIP_ENABLE: clip_on <= cfg_data[0];
          REG_RHO_MINIMUM: bound_lo <= cfg_data;
          REG_RHO_MAXIMUM: bound_hi <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the residual-balancing rho predictor
// ----------------------------------------------------------------------------
// Drives directed corner transactions and then phases of random transactions
// under several clip settings, with random start gaps in all but one random
// phase. Checking happens in rho_checker; this module waits for the pipeline
// to drain and reports.
module tb_top;
  import admm_pkg::*;

  localparam int DRAIN_CYCLES = 200;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] primal_residual;
  logic [31:0] dual_residual;
  logic [31:0] primal_scale;
  logic [31:0] dual_scale;
  logic [31:0] rho_now;
  logic        cfg_we;
  logic [IdxBits-1:0] cfg_index;
  logic [CfgBits-1:0] cfg_data;
  logic        done;
  logic [31:0] rho_next;
  logic        saturated;
  int          pending;
  int          fail_count;
  int          sent;

  admm_rho_predictor u_dut (.*);

  rho_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // one value: mostly mid-range, sometimes extremes or tiny
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 15);
      3: return $urandom;
      4: return 32'd1 << $urandom_range(0, 31);
      default: return $urandom_range(1 << 12, 1 << 22);
    endcase
  endfunction

  task automatic write_reg(reg_index_t idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic issue(logic [31:0] p, logic [31:0] d, logic [31:0] ps,
                       logic [31:0] ds, logic [31:0] r, bit gaps);
    while (gaps && $urandom_range(0, 99) < 7) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    primal_residual <= p;
    dual_residual <= d;
    primal_scale <= ps;
    dual_scale <= ds;
    rho_now <= r;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [31:0] lo;
    sent = 0;
    rst = 1'b1;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    primal_residual = '0;
    dual_residual = '0;
    primal_scale = '0;
    dual_scale = '0;
    rho_now = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners at reset settings
    issue(0, 0, 0, 0, 0, 0);
    issue('1, '1, '1, '1, '1, 0);
    issue('1, 0, 0, 0, '1, 0);
    issue(0, '1, 0, 0, '1, 0);
    issue(32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 0);
    issue('1, 1, 0, '1, 32'h10000, 0);
    issue(1, '1, '1, 0, 32'h10000, 0);
    issue(32'h40000, 32'h10000, 32'h10000, 32'h10000, 32'h8000_0000, 0);
    drain();

    // clip off: overflow saturation path
    write_reg(REG_CLIP_ENABLE, 32'd0);
    issue('1, 0, 0, 0, '1, 0);
    issue('1, 1, 0, '1, 32'h10000, 0);
    issue(0, 0, 0, 0, 32'h1234, 0);
    issue(32'h10000, 32'h10000, 32'h10000, 32'h10000, '1, 0);
    drain();

    // crossed bounds and extreme bounds
    write_reg(REG_CLIP_ENABLE, 32'hFFFF_FFFF);
    write_reg(REG_RHO_MINIMUM, 32'h0010_0000);
    write_reg(REG_RHO_MAXIMUM, 32'h0000_1000);
    issue(32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 0);
    issue(0, 0, 0, 0, 0, 0);
    drain();
    write_reg(REG_RHO_MINIMUM, '1);
    write_reg(REG_RHO_MAXIMUM, '1);
    issue(32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 0);
    drain();
    write_reg(REG_RHO_MINIMUM, 32'd0);
    issue('1, 0, 0, 0, '1, 0);
    issue(0, 0, 0, 0, 0, 0);
    drain();

    // random phases, each with its own settings
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_CLIP_ENABLE, {31'd0, ph[0] ^ ph[2]});
      lo = (ph == 3) ? 32'd0 : pick_word();
      write_reg(REG_RHO_MINIMUM, lo);
      write_reg(REG_RHO_MAXIMUM, (ph == 5) ? pick_word() : lo + $urandom_range(0, 1 << 24));
      for (int i = 0; i < 190; i++)
        issue(pick_word(), pick_word(), pick_word(), pick_word(), pick_word(), ph != 2);
      drain();
    end

    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
